@@ hw/rtl/sts_pkg.sv @@
// Shared types and constants for the striped transfer splitter.
// No dependencies; imported by every module of the block.
package sts_pkg;

	// Fixed field widths of the request and part transfers
	localparam int FIELD_W = 48;
	localparam int RANK_W  = 6;

	// Defaults for the top-level parameters
	localparam int DEF_RANKS     = 64;
	localparam int DEF_ADDR_BITS = 48;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture a request
		logic div_step;   // one quotient bit of global_start / slice_size
		logic prep;       // first part distance to the slice end
		logic emit_part;  // write one part into the output register
		logic emit_err;   // write the single error result
	} sts_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic zero_cnt;   // byte count of the request is zero
		logic range_bad;  // request does not fit in RANKS slices
		logic div_last;   // current divide step is the final one
		logic part_last;  // current part finishes the request
		logic out_free;   // output register can take a result
	} sts_stat_t;

endpackage

@@ hw/rtl/sts_ctrl.sv @@
// Controller state machine for the striped transfer splitter.
// Depends on sts_pkg for the command and status structs.
module sts_ctrl import sts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  sts_stat_t stat,
	output sts_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_ERR   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Requests are taken only between transfers
	assign in_stall = (state_q != ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.zero_cnt) begin
					state_d = ST_IDLE;
				end else if (stat.range_bad) begin
					state_d = ST_ERR;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_part = 1'b1;
					if (stat.part_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/sts_datapath.sv @@
// Datapath of the striped transfer splitter: request registers, restoring
// divider for the first node rank, part generation and output register.
// Depends on sts_pkg for widths and the command and status structs.
module sts_datapath import sts_pkg::*; #(
	parameter int RANKS     = DEF_RANKS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sts_cmd_t           cmd,
	output sts_stat_t          stat,
	input  logic [FIELD_W-1:0] local_start,
	input  logic [FIELD_W-1:0] node_base,
	input  logic [FIELD_W-1:0] global_start,
	input  logic [FIELD_W-1:0] slice_size,
	input  logic [FIELD_W-1:0] byte_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] part_local,
	output logic [FIELD_W-1:0] part_remote,
	output logic [FIELD_W-1:0] part_length,
	output logic [RANK_W-1:0]  node_rank,
	output logic               last_part,
	output logic               range_error
);

	localparam int QB     = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int CNT_W  = (QB > 1) ? $clog2(QB) : 1;
	localparam int DIV_W  = FIELD_W + QB;
	localparam int SPAN_W = FIELD_W + $clog2(RANKS + 1);
	localparam logic [FIELD_W-1:0] AMASK = (ADDR_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
		FIELD_W'((65'd1 << ADDR_BITS) - 65'd1);

	logic [FIELD_W-1:0] loc_q;
	logic [FIELD_W-1:0] base_q;
	logic [FIELD_W-1:0] rem_q;
	logic [FIELD_W-1:0] slice_q;
	logic [FIELD_W-1:0] left_q;
	logic [FIELD_W-1:0] dist_q;
	logic [QB-1:0]      rank_q;
	logic [CNT_W-1:0]   div_cnt_q;
	logic               out_valid_q;

	logic [SPAN_W-1:0]  span;
	logic [SPAN_W-1:0]  end_pos;
	logic [DIV_W-1:0]   div_sub;
	logic               div_ge;
	logic               last;
	logic [FIELD_W-1:0] len;

	// Range check: global_start + byte_count against RANKS slices
	assign span    = SPAN_W'(slice_q) * SPAN_W'(RANKS);
	assign end_pos = SPAN_W'(rem_q) + SPAN_W'(left_q);

	// Restoring divide step, one quotient bit per cycle, MSB first
	assign div_sub = DIV_W'(slice_q) << div_cnt_q;
	assign div_ge  = (DIV_W'(rem_q) >= div_sub);

	// Part length: rest of the slice or what remains of the request
	assign last = (dist_q >= left_q);
	assign len  = last ? left_q : dist_q;

	assign stat.zero_cnt  = (left_q == '0);
	assign stat.range_bad = (slice_q == '0) || (end_pos > span);
	assign stat.div_last  = (div_cnt_q == '0);
	assign stat.part_last = last;
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			loc_q   <= local_start;
			base_q  <= node_base;
			rem_q   <= global_start;
			slice_q <= slice_size;
			left_q  <= byte_count;
			rank_q  <= '0;
		end else if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= rem_q - FIELD_W'(div_sub);
			end
			rank_q <= QB'({rank_q, div_ge});
		end else if (cmd.prep) begin
			dist_q <= slice_q - rem_q;
		end else if (cmd.emit_part) begin
			left_q <= last ? '0 : (left_q - dist_q);
			loc_q  <= loc_q + len;
			rem_q  <= '0;
			dist_q <= slice_q;
			rank_q <= rank_q + QB'(1);
		end
	end

	// Divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= CNT_W'(QB - 1);
		end else if (cmd.div_step && (div_cnt_q != '0)) begin
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_part || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_part) begin
			part_local  <= loc_q & AMASK;
			part_remote <= (base_q + rem_q) & AMASK;
			part_length <= len;
			node_rank   <= RANK_W'(rank_q);
			last_part   <= last;
			range_error <= 1'b0;
		end else if (cmd.emit_err) begin
			part_local  <= '0;
			part_remote <= '0;
			part_length <= '0;
			node_rank   <= '0;
			last_part   <= 1'b1;
			range_error <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/striped_transfer_splitter_unit.sv @@
// Flow: after accept the controller walks a check state, the bit-serial
// divide state and a setup state before the first part is loaded. Then
// one part per cycle while out_stall is low. A new request is taken only
// once the last part, the error result or a zero byte count has finished;
// an error request goes from check to the error state, a zero byte count
// straight back to idle. Reset: arst_n clears the controller and valid.
module striped_transfer_splitter_unit import sts_pkg::*; #(
	parameter int RANKS     = DEF_RANKS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [FIELD_W-1:0] local_start,
	input  logic [FIELD_W-1:0] node_base,
	input  logic [FIELD_W-1:0] global_start,
	input  logic [FIELD_W-1:0] slice_size,
	input  logic [FIELD_W-1:0] byte_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] part_local,
	output logic [FIELD_W-1:0] part_remote,
	output logic [FIELD_W-1:0] part_length,
	output logic [RANK_W-1:0]  node_rank,
	output logic               last_part,
	output logic               range_error
);

	sts_cmd_t  cmd;
	sts_stat_t stat;

	// Controller
	sts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	sts_datapath #(
		.RANKS     (RANKS),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.local_start  (local_start),
		.node_base    (node_base),
		.global_start (global_start),
		.slice_size   (slice_size),
		.byte_count   (byte_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.part_local   (part_local),
		.part_remote  (part_remote),
		.part_length  (part_length),
		.node_rank    (node_rank),
		.last_part    (last_part),
		.range_error  (range_error)
	);

`ifndef SYNTHESIS
	// A result is never written over one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_part || cmd.emit_err) |-> (!out_valid || !out_stall))
		else $error("result written while output transfer stalled");

	// A freshly loaded request is checked before anything is emitted
	a_load_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !(cmd.emit_part || cmd.emit_err || cmd.div_step))
		else $error("emit or divide directly after request load");

	// An error result is the only and final result of its request
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (last_part && (part_length == '0)))
		else $error("error result not marked last or carries a length");
`endif

endmodule

@@ bench/striped_transfer_splitter_unit_tb.sv @@
// Self-checking bench for striped_transfer_splitter_unit: directed and random
// requests, a scoreboard that predicts the per-node parts of each request.
// Depends on sts_pkg and the unit RTL only.
module striped_transfer_splitter_unit_tb;
	import sts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANKS     = DEF_RANKS;
	localparam int ADDR_BITS = DEF_ADDR_BITS;
	localparam int LONG_HOLD = 400;
	localparam bit [63:0] FIELD_MAX = (64'd1 << FIELD_W) - 1;
	localparam bit [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 1);

	typedef struct packed {
		logic [FIELD_W-1:0] local_start;
		logic [FIELD_W-1:0] node_base;
		logic [FIELD_W-1:0] global_start;
		logic [FIELD_W-1:0] slice_size;
		logic [FIELD_W-1:0] byte_count;
	} xfer_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] part_local;
		logic [FIELD_W-1:0] part_remote;
		logic [FIELD_W-1:0] part_length;
		logic [RANK_W-1:0]  node_rank;
		logic               last_part;
		logic               range_error;
	} xfer_part_t;

	// Predicts the parts of each accepted request and checks the parts that come out
	class split_scoreboard;
		xfer_part_t pending_parts[$];
		int mismatches;
		int requests;
		int zero_requests;
		int parts_checked;
		int range_errors;

		function int pending();
			return pending_parts.size();
		endfunction

		function void report(string what, xfer_part_t exp, xfer_part_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $realtime, what);
				$display("  exp local=%h remote=%h len=%h rank=%0d last=%b err=%b",
					exp.part_local, exp.part_remote, exp.part_length, exp.node_rank,
					exp.last_part, exp.range_error);
				$display("  got local=%h remote=%h len=%h rank=%0d last=%b err=%b",
					got.part_local, got.part_remote, got.part_length, got.node_rank,
					got.last_part, got.range_error);
			end
		endfunction

		// Split one request into per-node parts, or one error result if out of range
		function void note_request(xfer_req_t rq);
			bit [63:0] loc, base, pos, slice, left, span, slice_off, len, sum;
			xfer_part_t p;
			int k;
			loc   = 64'(rq.local_start) & ADDR_MASK;
			base  = 64'(rq.node_base);
			pos   = 64'(rq.global_start);
			slice = 64'(rq.slice_size);
			left  = 64'(rq.byte_count);
			requests++;
			if (left == 0) begin
				zero_requests++;
				return;
			end
			span = 64'(RANKS) * slice;
			// whole request checked first; zero slice counts as out of range
			if (slice == 0 || pos + left > span) begin
				p = '0;
				p.last_part = 1'b1;
				p.range_error = 1'b1;
				pending_parts.push_back(p);
				return;
			end
			k = 0;
			while (left != 0 && k < RANKS) begin
				slice_off = pos % slice;
				len = slice - slice_off;
				if (len > left)
					len = left;
				left -= len;
				sum = (base + slice_off) & ADDR_MASK;
				p.part_local  = loc[FIELD_W-1:0];
				p.part_remote = sum[FIELD_W-1:0];
				p.part_length = len[FIELD_W-1:0];
				sum = pos / slice;
				p.node_rank   = sum[RANK_W-1:0];
				p.last_part   = (left == 0);
				p.range_error = 1'b0;
				pending_parts.push_back(p);
				k++;
				loc = (loc + len) & ADDR_MASK;
				pos += len;
			end
		endfunction

		function void check_part(xfer_part_t got);
			xfer_part_t exp;
			string diff;
			parts_checked++;
			if (got.range_error)
				range_errors++;
			if (pending_parts.size() == 0) begin
				report("part with nothing expected", '0, got);
				return;
			end
			exp = pending_parts.pop_front();
			diff = "";
			if (got.part_local !== exp.part_local)
				diff = {diff, " part_local"};
			if (got.part_remote !== exp.part_remote)
				diff = {diff, " part_remote"};
			if (got.part_length !== exp.part_length)
				diff = {diff, " part_length"};
			if (got.node_rank !== exp.node_rank)
				diff = {diff, " node_rank"};
			if (got.last_part !== exp.last_part)
				diff = {diff, " last_part"};
			if (got.range_error !== exp.range_error)
				diff = {diff, " range_error"};
			if (diff != "")
				report({"field mismatch:", diff}, exp, got);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [FIELD_W-1:0] local_start = '0;
	logic [FIELD_W-1:0] node_base = '0;
	logic [FIELD_W-1:0] global_start = '0;
	logic [FIELD_W-1:0] slice_size = '0;
	logic [FIELD_W-1:0] byte_count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [FIELD_W-1:0] part_local;
	logic [FIELD_W-1:0] part_remote;
	logic [FIELD_W-1:0] part_length;
	logic [RANK_W-1:0]  node_rank;
	logic               last_part;
	logic               range_error;

	xfer_part_t seen_part;
	split_scoreboard sb = new;

	int tx_idle_pct = 12;
	int rx_idle_pct = 68;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;

	assign seen_part = {part_local, part_remote, part_length, node_rank, last_part,
		range_error};

	striped_transfer_splitter_unit #(
		.RANKS    (RANKS),
		.ADDR_BITS(ADDR_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.local_start (local_start),
		.node_base   (node_base),
		.global_start(global_start),
		.slice_size  (slice_size),
		.byte_count  (byte_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.part_local  (part_local),
		.part_remote (part_remote),
		.part_length (part_length),
		.node_rank   (node_rank),
		.last_part   (last_part),
		.range_error (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#12_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Output side: check accepted parts, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_part(seen_part);
		if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	function automatic bit [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic bit [FIELD_W-1:0] rand48();
		bit [63:0] r;
		r = rand64();
		return r[FIELD_W-1:0];
	endfunction

	function automatic xfer_req_t mk(bit [63:0] loc, bit [63:0] base, bit [63:0] pos,
			bit [63:0] slice, bit [63:0] cnt);
		xfer_req_t rq;
		rq.local_start  = loc[FIELD_W-1:0];
		rq.node_base    = base[FIELD_W-1:0];
		rq.global_start = pos[FIELD_W-1:0];
		rq.slice_size   = slice[FIELD_W-1:0];
		rq.byte_count   = cnt[FIELD_W-1:0];
		return rq;
	endfunction

	// Request that fits inside the stripe, spanning a few or many slices
	function automatic xfer_req_t make_striped();
		bit [63:0] s, max_first, r0, r1, w, w2, pos, stop, cnt, nparts;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: s = $urandom_range(64, 1);
			5, 6: s = $urandom_range(1 << 20, 65);
			7, 8: s = (rand64() % (64'd1 << 41)) + 1;
			default: s = FIELD_MAX - (rand64() % (64'd1 << 47));
		endcase
		max_first = FIELD_MAX / s;
		if (max_first > RANKS - 1)
			max_first = RANKS - 1;
		r0 = rand64() % (max_first + 1);
		w = rand64() % s;
		pos = r0 * s + w;
		if (pos > FIELD_MAX)
			pos = r0 * s;
		nparts = ($urandom_range(9) < 7) ? $urandom_range(8, 1) : $urandom_range(RANKS, 1);
		r1 = r0 + nparts - 1;
		if (r1 > RANKS - 1)
			r1 = RANKS - 1;
		w2 = (rand64() % s) + 1;
		stop = r1 * s + w2;
		if (stop <= pos)
			stop = pos + 1;
		cnt = stop - pos;
		if (cnt > FIELD_MAX)
			cnt = FIELD_MAX;
		return mk(rand48(), rand48(), pos, s, cnt);
	endfunction

	// Request that runs past the last slice, or starts beyond it
	function automatic xfer_req_t make_overrun();
		bit [63:0] s, span, pos, cnt;
		s = ($urandom_range(3) == 0) ? $urandom_range(1 << 30, 1) : $urandom_range(4096, 1);
		span = 64'(RANKS) * s;
		if ($urandom_range(3) == 0) begin
			pos = span + $urandom_range(1000);
			cnt = $urandom_range(1000, 1);
		end else begin
			pos = rand64() % (span + 1);
			cnt = span - pos + 1 + $urandom_range(100);
		end
		return mk(rand48(), rand48(), pos, s, cnt);
	endfunction

	function automatic xfer_req_t make_request();
		xfer_req_t rq;
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) begin
			rq = make_striped();
		end else if (pick < 83) begin
			rq = make_overrun();
		end else if (pick < 88) begin
			rq = mk(rand48(), rand48(), rand48(), rand48(), 0);
		end else if (pick < 91) begin
			rq = mk(rand48(), rand48(), rand48(), 0, rand48());
			if (rq.byte_count == 0)
				rq.byte_count = 1;
		end else begin
			rq = mk(rand48(), rand48(), rand48(), rand48(), rand48());
		end
		return rq;
	endfunction

	// Offer one request and hold it until the transfer is taken
	task automatic send_request(xfer_req_t rq);
		local_start  <= rq.local_start;
		node_base    <= rq.node_base;
		global_start <= rq.global_start;
		slice_size   <= rq.slice_size;
		byte_count   <= rq.byte_count;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(rq);
	endtask

	task automatic sender_gap();
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// Stop offering until every predicted part has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic run_random(int n);
		xfer_req_t rq;
		int done;
		done = 0;
		while (done < n) begin
			rq = make_request();
			send_request(rq);
			if (rq.byte_count != 0)
				done++;
			sender_gap();
		end
	endtask

	task automatic run_directed();
		xfer_req_t list[$];
		list.push_back(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, 0));
		list.push_back(mk(0, 0, 0, 0, 0));
		list.push_back(mk(7, 9, 0, 0, 1));
		list.push_back(mk(0, 0, 0, 1, 64));
		list.push_back(mk(0, 0, 0, 1, 65));
		list.push_back(mk(5, 5, 63, 1, 1));
		list.push_back(mk(0, 0, 0, FIELD_MAX, FIELD_MAX));
		list.push_back(mk(1, 2, FIELD_MAX, FIELD_MAX, FIELD_MAX));
		// local and remote sums wrap around the address space
		list.push_back(mk(FIELD_MAX - 20, FIELD_MAX - 3, 8, 16, 40));
		list.push_back(mk(0, 100, 63000, 1000, 1000));
		list.push_back(mk(0, 100, 63000, 1000, 1001));
		list.push_back(mk(0, 0, 50, 100, 100));
		list.push_back(mk(0, 0, FIELD_MAX, 64'd1 << 42, 1));
		list.push_back(mk(FIELD_MAX, 0, FIELD_MAX, 1, FIELD_MAX));
		list.push_back(mk(123, 456, 3 * 777, 777, 777));
		list.push_back(mk(0, 0, 0, 3, 192));
		list.push_back(mk(64'd1 << 47, 64'd1 << 47, 0, 64'd1 << 47, 64'd1 << 47));
		foreach (list[i]) begin
			send_request(list[i]);
			sender_gap();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalled
		run_directed();
		run_random(85);
		wait_drained();

		// Sender mostly idle, receiver mostly ready
		tx_idle_pct = 68;
		rx_idle_pct = 12;
		run_random(85);
		wait_drained();

		// No idling; a long output hold at the start backs the unit up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_ticket++;
		run_random(80);
		wait_drained();
		repeat (64) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("%0d expected parts never arrived", sb.pending());
			sb.mismatches += sb.pending();
		end
		$display("Run covered %0d requests (%0d of zero length), %0d parts, %0d range errors.",
			sb.requests, sb.zero_requests, sb.parts_checked, sb.range_errors);
		$display("Idling swept: sender-heavy, receiver-heavy, none, plus one long output hold.");
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ striped_transfer_splitter_unit.f @@
hw/rtl/sts_pkg.sv
hw/rtl/sts_ctrl.sv
hw/rtl/sts_datapath.sv
hw/rtl/striped_transfer_splitter_unit.sv
bench/striped_transfer_splitter_unit_tb.sv
